// ----- sv/spc_pkg.sv -----
package spc_pkg;

    // Frame offsets at or above this count are held at the last frame.
    localparam int unsigned MAX_FRAMES = 4096;

    localparam logic [31:0] SPQ_RESET = 32'd98304000;
    localparam logic [23:0] QPC_RESET = 24'd65536;

    // Shared divider widths: dividend shift line, partial remainder, quotient.
    localparam int unsigned DVD_W = 77;
    localparam int unsigned REM_W = 41;
    localparam int unsigned QUO_W = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_POS,
        ST_DIV2,
        ST_FIX,
        ST_SEL,
        ST_DIV3,
        ST_FIN
    } t_state;

    typedef enum logic {
        REG_SPQ = 1'b0,
        REG_QPC = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [REM_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
        logic [REM_W-1:0] div;
    } t_div_ctrl;

    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] div;
    } t_div_stat;

endpackage

// ----- sv/swung_phase_clock.sv -----
// Swung phase clock: one input item per audio frame, one result item per input item.
// The frame's position in quarter notes (host position plus offset, or sample count
// divided by samples per quarter) is split into pairs of cycles, the swing moves the
// boundary inside each pair, and the result carries the ramp phase and a trigger on
// every change of cycle index. All division runs on one restoring divider that takes
// one quotient bit per clock: 77 steps for the position, 64 for the pair index and
// 16 for the phase. Around the divisions an item also passes the accept state, the
// position and pair fix-up states, the split select state and the result load state;
// a new item is accepted only once the previous one has passed all of them, and the
// result load waits while the output is stalled. The input side takes the next item
// while the previous result still waits on the output register.
module swung_phase_clock (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [39:0] host_position, [87:40] sample_position, [99:88] frame_offset,
    // [115:100] swing_amount, [119:116] zero
    input  logic [119:0] s_axis_tdata,
    // [0] playing
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] phase
    output logic [15:0]  m_axis_tdata,
    // [0] trigger
    output logic         m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import spc_pkg::*;

    localparam logic [6:0]  DIV1_STEPS = 7'd77;
    localparam logic [6:0]  DIV2_STEPS = 7'd64;
    localparam logic [6:0]  DIV3_STEPS = 7'd16;
    localparam logic [16:0] FO_LIMIT   = 17'(MAX_FRAMES - 1);
    localparam logic [16:0] UNIT       = 17'h10000;

    t_state        r_state;
    t_state        n_state;
    logic [6:0]    r_cnt;
    logic [31:0]   r_spq;
    logic [23:0]   r_qpc;
    logic          r_play;
    logic [39:0]   r_host;
    logic [15:0]   r_a;
    logic [23:0]   r_q;
    logic [40:0]   r_split;
    logic [40:0]   r_s2;
    logic          r_neg;
    logic [63:0]   r_cyc;
    logic [24:0]   r_m;
    logic [63:0]   r_prev;
    logic          r_mvalid;
    logic [15:0]   r_phase;
    logic          r_trig;

    t_div_ctrl     div_ctrl;
    t_div_stat     div_stat;

    logic          in_take;
    logic          out_load;
    logic          cfg_wr;
    logic [39:0]   in_host;
    logic [47:0]   in_spos;
    logic [11:0]   in_fo;
    logic [15:0]   in_a;
    logic [11:0]   fo_sat;
    logic [48:0]   spos_sum;
    logic [60:0]   pos_num;
    logic [31:0]   spq_eff;
    logic [23:0]   q_eff;
    logic [63:0]   x_pos;
    logic [63:0]   x_mag;
    logic [16:0]   a_plus;
    logic [16:0]   a_minus;
    logic [24:0]   dbl_q;
    logic [63:0]   pair;
    logic [24:0]   m_val;
    logic [40:0]   m_scaled;
    logic          m_low;

    spc_div_unit u_div (
        .i_clk  (i_clk),
        .i_ctrl (div_ctrl),
        .o_stat (div_stat)
    );

    assign in_host = s_axis_tdata[39:0];
    assign in_spos = s_axis_tdata[87:40];
    assign in_fo   = s_axis_tdata[99:88];
    assign in_a    = s_axis_tdata[115:100];

    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == ST_FIN) && (!r_mvalid || m_axis_tready);
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign fo_sat   = ({5'b0, in_fo} > FO_LIMIT) ? FO_LIMIT[11:0] : in_fo;
    assign spos_sum = {1'b0, in_spos} + {37'b0, fo_sat};
    assign pos_num  = s_axis_tuser ? {37'b0, fo_sat, 12'b0} : {spos_sum, 12'b0};
    assign spq_eff  = (r_spq == '0) ? 32'd1 : r_spq;
    assign q_eff    = (r_qpc == '0) ? 24'd1 : r_qpc;

    // Position in quarters, Q47.16, wrapping in 64 bits.
    assign x_pos = r_play ? ({{24{r_host[39]}}, r_host} + div_stat.quo) : div_stat.quo;
    assign x_mag = x_pos[63] ? (~x_pos + 64'd1) : x_pos;

    assign a_plus  = UNIT + {1'b0, r_a};
    assign a_minus = UNIT - {1'b0, r_a};
    assign dbl_q   = {r_q, 1'b0};

    // Turn the magnitude division back into a floor division for negative positions.
    always_comb begin
        pair  = div_stat.quo;
        m_val = div_stat.rem[24:0];
        if (r_neg) begin
            if (div_stat.rem[24:0] == '0) begin
                pair  = ~div_stat.quo + 64'd1;
                m_val = '0;
            end else begin
                pair  = ~div_stat.quo;
                m_val = dbl_q - div_stat.rem[24:0];
            end
        end
    end

    assign m_scaled = {r_m, 16'b0};
    assign m_low    = m_scaled < r_split;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_take) n_state = ST_DIV1;
            ST_DIV1: if (r_cnt == 7'd1) n_state = ST_POS;
            ST_POS:  n_state = ST_DIV2;
            ST_DIV2: if (r_cnt == 7'd1) n_state = ST_FIX;
            ST_FIX:  n_state = ST_SEL;
            ST_SEL:  n_state = ST_DIV3;
            ST_DIV3: if (r_cnt == 7'd1) n_state = ST_FIN;
            ST_FIN:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        div_ctrl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                div_ctrl.load = in_take;
                div_ctrl.dvd  = {pos_num, 16'b0};
                div_ctrl.div  = {9'b0, spq_eff};
            end
            ST_DIV1, ST_DIV2, ST_DIV3: begin
                div_ctrl.step = 1'b1;
            end
            ST_POS: begin
                div_ctrl.load = 1'b1;
                div_ctrl.dvd  = {x_mag, 13'b0};
                div_ctrl.div  = {16'b0, dbl_q};
            end
            ST_SEL: begin
                div_ctrl.load = 1'b1;
                div_ctrl.rem  = m_low ? m_scaled : (m_scaled - r_split);
                div_ctrl.div  = m_low ? r_split : r_s2;
            end
            ST_FIX, ST_FIN: begin
                div_ctrl = '0;
            end
            default: div_ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_spq    <= SPQ_RESET;
            r_qpc    <= QPC_RESET;
            r_prev   <= '1;
            r_mvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                unique case (t_reg_idx'(paddr[2]))
                    REG_SPQ: r_spq <= pwdata;
                    REG_QPC: r_qpc <= pwdata[23:0];
                    default: r_spq <= r_spq;
                endcase
            end
            unique case (r_state)
                ST_IDLE: if (in_take) r_cnt <= DIV1_STEPS;
                ST_POS:  r_cnt <= DIV2_STEPS;
                ST_SEL:  r_cnt <= DIV3_STEPS;
                ST_DIV1, ST_DIV2, ST_DIV3: r_cnt <= r_cnt - 7'd1;
                default: r_cnt <= r_cnt;
            endcase
            if (out_load) begin
                r_mvalid <= 1'b1;
                r_prev   <= r_cyc;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    r_play <= s_axis_tuser;
                    r_host <= in_host;
                    r_a    <= in_a;
                    r_q    <= q_eff;
                end
            end
            ST_POS: begin
                r_neg   <= x_pos[63];
                r_split <= {17'b0, r_q} * {24'b0, a_plus};
            end
            ST_FIX: begin
                r_cyc <= {pair[62:0], 1'b0};
                r_m   <= m_val;
                r_s2  <= {17'b0, r_q} * {24'b0, a_minus};
            end
            ST_SEL: begin
                r_cyc[0] <= !m_low;
            end
            ST_FIN: begin
                if (out_load) begin
                    r_phase <= (div_stat.quo[63:16] != '0) ? 16'hFFFF : div_stat.quo[15:0];
                    r_trig  <= r_cyc != r_prev;
                end
            end
            default: r_neg <= r_neg;
        endcase
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_phase;
    assign m_axis_tuser  = r_trig;

    assign pready = 1'b1;
    assign prdata = (t_reg_idx'(paddr[2]) == REG_QPC) ? {8'b0, r_qpc} : r_spq;

    // An accepted item keeps the input side closed for the whole computation.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !s_axis_tready)
        else $error("input accepted again right after an item");

    // The divider must never run out of steps inside a division state.
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV1 || r_state == ST_DIV2 || r_state == ST_DIV3)
        |-> r_cnt != 7'd0)
        else $error("divider step count reached zero while dividing");

    // A partial remainder at or above the divisor means a bad load or a lost step.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV1 || r_state == ST_DIV2 || r_state == ST_DIV3)
        |-> div_stat.rem < div_stat.div)
        else $error("divider remainder not below divisor");

    // A result is loaded only when the output register is free or being emptied.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mvalid && !m_axis_tready && r_state == ST_FIN) |=> r_state == ST_FIN)
        else $error("result left the final state while output was stalled");

endmodule

// ----- sv/spc_div_unit.sv -----
module spc_div_unit (
    input  logic               i_clk,
    input  spc_pkg::t_div_ctrl i_ctrl,
    output spc_pkg::t_div_stat o_stat
);
    import spc_pkg::*;

    logic [REM_W-1:0] r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [QUO_W-1:0] r_quo;
    logic [REM_W-1:0] r_div;

    logic [REM_W:0]   shifted;
    logic [REM_W+1:0] diff;
    logic             fits;

    // One restoring step: bring in the next dividend bit and try a subtract.
    assign shifted = {r_rem, r_dvd[DVD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_div};
    assign fits    = ~diff[REM_W+1];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rem <= i_ctrl.rem;
            r_dvd <= i_ctrl.dvd;
            r_div <= i_ctrl.div;
            r_quo <= '0;
        end else if (i_ctrl.step) begin
            r_rem <= fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_stat.quo = r_quo;
    assign o_stat.rem = r_rem;
    assign o_stat.div = r_div;

endmodule
